/* hdl/e2q_pkg.sv */
// Shared constants and types for the Euler-to-quaternion converter.
package e2q_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int ATAN_ENTRIES        = 24;

    // Q30 working width: covers 2*pi in Q30 plus sign and headroom.
    localparam int ZW = 36;
    localparam int XW = 33;

    localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

    typedef logic signed [15:0] angle_t;
    typedef logic signed [15:0] q15_t;
    typedef logic signed [15:0] q14_t;

    // Arctangent of 2^-i, Q30, truncated.
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] r;
        begin
            r = '0;
            case (idx)
                0:  r = 36'sh03243F6A8;
                1:  r = 36'sh01DAC6705;
                2:  r = 36'sh00FADBAFC;
                3:  r = 36'sh007F56EA6;
                4:  r = 36'sh003FEAB76;
                5:  r = 36'sh001FFD55B;
                6:  r = 36'sh000FFFAAA;
                7:  r = 36'sh0007FFF55;
                8:  r = 36'sh0003FFFEA;
                9:  r = 36'sh0001FFFFD;
                10: r = 36'sh0000FFFFF;
                11: r = 36'sh00007FFFF;
                12: r = 36'sh00003FFFF;
                13: r = 36'sh00001FFFF;
                14: r = 36'sh00000FFFF;
                15: r = 36'sh000007FFF;
                16: r = 36'sh000003FFF;
                17: r = 36'sh000001FFF;
                18: r = 36'sh000000FFF;
                19: r = 36'sh0000007FF;
                20: r = 36'sh0000003FF;
                21: r = 36'sh0000001FF;
                22: r = 36'sh0000000FF;
                23: r = 36'sh00000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Per-angle CORDIC state carried between cells.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        rot_t roll;
        rot_t pitch;
        rot_t yaw;
        logic [2:0] flip;
    } cell_data_t;

endpackage

/* hdl/e2q_if.sv */
// Valid/ready channel interfaces for angle input and quaternion output.
interface e2q_angle_if;
    logic valid;
    logic ready;
    e2q_pkg::angle_t roll_angle;
    e2q_pkg::angle_t pitch_angle;
    e2q_pkg::angle_t yaw_angle;
    modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                    input ready);
    modport sink (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

interface e2q_quat_if;
    logic valid;
    logic ready;
    e2q_pkg::q14_t quat_scalar;
    e2q_pkg::q14_t quat_x;
    e2q_pkg::q14_t quat_y;
    e2q_pkg::q14_t quat_z;
    modport source (output valid, output quat_scalar, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink (input valid, input quat_scalar, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

/* hdl/e2q_cell.sv */
// One CORDIC micro-rotation cell, applied to all three angles in parallel.
module e2q_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  e2q_pkg::cell_data_t  in_data,
    output logic                 out_valid,
    output e2q_pkg::cell_data_t  out_data
);
    localparam logic signed [e2q_pkg::ZW-1:0] ATAN = e2q_pkg::atan_q30(STAGE);

    logic                valid_reg;
    e2q_pkg::cell_data_t data_reg;
    e2q_pkg::cell_data_t data_next;

    function automatic e2q_pkg::rot_t rotate(input e2q_pkg::rot_t r);
        e2q_pkg::rot_t o;
        logic signed [e2q_pkg::XW-1:0] dx;
        logic signed [e2q_pkg::XW-1:0] dy;
        begin
            dx = r.y >>> STAGE;
            dy = r.x >>> STAGE;
            if (!r.z[e2q_pkg::ZW-1])
            begin
                o.x = r.x - dx;
                o.y = r.y + dy;
                o.z = r.z - ATAN;
            end
            else
            begin
                o.x = r.x + dx;
                o.y = r.y - dy;
                o.z = r.z + ATAN;
            end
            return o;
        end
    endfunction

    always_comb
    begin
        data_next.roll  = rotate(in_data.roll);
        data_next.pitch = rotate(in_data.pitch);
        data_next.yaw   = rotate(in_data.yaw);
        data_next.flip  = in_data.flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

/* hdl/e2q_prep.sv */
// Input stage: half angle in Q30, wrap to (-pi, pi], quadrant pre-rotation.
module e2q_prep #(
    parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  e2q_pkg::angle_t      roll_angle,
    input  e2q_pkg::angle_t      pitch_angle,
    input  e2q_pkg::angle_t      yaw_angle,
    output logic                 out_valid,
    output e2q_pkg::cell_data_t  out_data
);
    localparam int SH = 29 - ANGLE_FRAC_BITS;

    logic                valid_reg;
    e2q_pkg::cell_data_t data_reg;
    e2q_pkg::cell_data_t data_next;
    logic [2:0]          flip_w;
    e2q_pkg::rot_t       r_roll;
    e2q_pkg::rot_t       r_pitch;
    e2q_pkg::rot_t       r_yaw;

    // Half angles reach at most +-2^(15+SH), i.e. under 6*pi at the fewest fraction
    // bits, so three wrap steps suffice.
    function automatic e2q_pkg::rot_t prep(input e2q_pkg::angle_t a, output logic f);
        logic signed [e2q_pkg::ZW-1:0] z;
        e2q_pkg::rot_t o;
        begin
            z = e2q_pkg::ZW'(a) <<< SH;
            if (z > e2q_pkg::Q30_PI)
                z = z - e2q_pkg::Q30_TWO_PI;
            else if (z <= -e2q_pkg::Q30_PI)
                z = z + e2q_pkg::Q30_TWO_PI;
            if (z > e2q_pkg::Q30_PI)
                z = z - e2q_pkg::Q30_TWO_PI;
            else if (z <= -e2q_pkg::Q30_PI)
                z = z + e2q_pkg::Q30_TWO_PI;
            if (z > e2q_pkg::Q30_PI)
                z = z - e2q_pkg::Q30_TWO_PI;
            else if (z <= -e2q_pkg::Q30_PI)
                z = z + e2q_pkg::Q30_TWO_PI;
            f = 1'b0;
            if (z > e2q_pkg::Q30_HALF_PI)
            begin
                z = z - e2q_pkg::Q30_PI;
                f = 1'b1;
            end
            else if (z < -e2q_pkg::Q30_HALF_PI)
            begin
                z = z + e2q_pkg::Q30_PI;
                f = 1'b1;
            end
            o.x = e2q_pkg::CORDIC_GAIN;
            o.y = '0;
            o.z = z;
            return o;
        end
    endfunction

    always_comb
    begin
        r_roll  = prep(roll_angle,  flip_w[0]);
        r_pitch = prep(pitch_angle, flip_w[1]);
        r_yaw   = prep(yaw_angle,   flip_w[2]);
        data_next.roll  = r_roll;
        data_next.pitch = r_pitch;
        data_next.yaw   = r_yaw;
        data_next.flip  = flip_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

/* hdl/e2q_combine.sv */
// Back end: round to Q15, form triple products, sum, round and saturate to Q1.14.
module e2q_combine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  e2q_pkg::cell_data_t  in_data,
    output logic                 out_valid,
    output e2q_pkg::q14_t        quat_scalar,
    output e2q_pkg::q14_t        quat_x,
    output e2q_pkg::q14_t        quat_y,
    output e2q_pkg::q14_t        quat_z
);
    // Stage 1: cos/sin rounded to Q15 (17 bits keeps +-1.0 safe).
    logic signed [16:0] cp_reg, sp_reg, ct_reg, st_reg, cy_reg, sy_reg;
    // Stage 2: yaw x pitch pair products, Q30.
    logic signed [33:0] cc_reg, ss_reg, cs_reg, sc_reg;
    logic signed [16:0] cp2_reg, sp2_reg;
    // Stage 3: triple products, Q45.
    logic signed [50:0] p_ccc_reg, p_sss_reg, p_ccs_reg, p_ssc_reg;
    logic signed [50:0] p_csc_reg, p_scs_reg, p_scc_reg, p_css_reg;
    logic [3:0] v_reg;
    e2q_pkg::q14_t q0_reg, q1_reg, q2_reg, q3_reg;

    function automatic logic signed [16:0] rnd15(input logic signed [e2q_pkg::XW-1:0] v,
                                                 input logic f);
        logic signed [e2q_pkg::XW:0] t;
        begin
            t = f ? -(e2q_pkg::XW+1)'(v) : (e2q_pkg::XW+1)'(v);
            t = (t + (e2q_pkg::XW+1)'(34'sd16384)) >>> 15;
            return t[16:0];
        end
    endfunction

    function automatic e2q_pkg::q14_t fin(input logic signed [51:0] s);
        logic signed [51:0] q;
        begin
            q = (s + 52'sd1073741824) >>> 31;
            if (q > 52'sd16384)
                q = 52'sd16384;
            else if (q < -52'sd16384)
                q = -52'sd16384;
            return q[15:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= rnd15(in_data.roll.x,  in_data.flip[0]);
            sp_reg <= rnd15(in_data.roll.y,  in_data.flip[0]);
            ct_reg <= rnd15(in_data.pitch.x, in_data.flip[1]);
            st_reg <= rnd15(in_data.pitch.y, in_data.flip[1]);
            cy_reg <= rnd15(in_data.yaw.x,   in_data.flip[2]);
            sy_reg <= rnd15(in_data.yaw.y,   in_data.flip[2]);

            cc_reg  <= 34'(cy_reg * ct_reg);
            ss_reg  <= 34'(sy_reg * st_reg);
            cs_reg  <= 34'(cy_reg * st_reg);
            sc_reg  <= 34'(sy_reg * ct_reg);
            cp2_reg <= cp_reg;
            sp2_reg <= sp_reg;

            p_ccc_reg <= 51'(cc_reg * cp2_reg);
            p_sss_reg <= 51'(ss_reg * sp2_reg);
            p_ccs_reg <= 51'(cc_reg * sp2_reg);
            p_ssc_reg <= 51'(ss_reg * cp2_reg);
            p_csc_reg <= 51'(cs_reg * cp2_reg);
            p_scs_reg <= 51'(sc_reg * sp2_reg);
            p_scc_reg <= 51'(sc_reg * cp2_reg);
            p_css_reg <= 51'(cs_reg * sp2_reg);

            q0_reg <= fin(52'(p_ccc_reg) + 52'(p_sss_reg));
            q1_reg <= fin(52'(p_ccs_reg) - 52'(p_ssc_reg));
            q2_reg <= fin(52'(p_csc_reg) + 52'(p_scs_reg));
            q3_reg <= fin(52'(p_scc_reg) - 52'(p_css_reg));
        end
    end

    assign out_valid   = v_reg[3];
    assign quat_scalar = q0_reg;
    assign quat_x      = q1_reg;
    assign quat_y      = q2_reg;
    assign quat_z      = q3_reg;

    a_sat0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_scalar <= 16'sd16384 && quat_scalar >= -16'sd16384))
        else $error("quat_scalar out of range");
    a_sat1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
        else $error("quat_z out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while stalled");
endmodule

/* hdl/euler_to_quaternion_top.sv */
// Top level: Euler ZYX angles to quaternion, pipelined CORDIC cell chain.
//
// Usage:
//   angles: sink channel carrying roll_angle, pitch_angle, yaw_angle (signed,
//           ANGLE_FRAC_BITS fraction bits, radians). One word per accepted beat.
//   quat:   source channel carrying quat_scalar, quat_x, quat_y, quat_z in
//           signed Q1.14, saturated to +-1.0.
// Structure: one prep stage (halve, wrap, quadrant flip), a chain of
//   CORDIC_STAGES cells of one module, each doing one micro-rotation for all three
//   angles, then a 4-stage back end (round, pair products, triple products,
//   sum/round/saturate), whose last stage is the output register.
// Throughput: one word per cycle unless the output stalls; every stage is a register of the chain.
// Stall: the whole pipeline freezes only when the output holds a valid word
//   that the receiver does not take; otherwise bubbles drain and new words
//   enter. angles.ready = !quat.valid || quat.ready.
// Reset: rst_n clears all valid flags asynchronously; no words are in flight
//   afterwards. The data registers are not reset.
module euler_to_quaternion_top #(
    parameter int CORDIC_STAGES   = e2q_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    e2q_angle_if.sink angles,
    e2q_quat_if.source quat
);
    logic en;
    logic                v_chain [CORDIC_STAGES+1];
    e2q_pkg::cell_data_t d_chain [CORDIC_STAGES+1];

    // Single global enable: advance unless the output word is stuck.
    assign en = !quat.valid || quat.ready;
    assign angles.ready = en;

    e2q_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (angles.valid),
        .roll_angle (angles.roll_angle),
        .pitch_angle(angles.pitch_angle),
        .yaw_angle  (angles.yaw_angle),
        .out_valid  (v_chain[0]),
        .out_data   (d_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        e2q_cell #(.STAGE(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_chain[g]),
            .in_data  (d_chain[g]),
            .out_valid(v_chain[g+1]),
            .out_data (d_chain[g+1])
        );
    end

    e2q_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v_chain[CORDIC_STAGES]),
        .in_data    (d_chain[CORDIC_STAGES]),
        .out_valid  (quat.valid),
        .quat_scalar(quat.quat_scalar),
        .quat_x     (quat.quat_x),
        .quat_y     (quat.quat_y),
        .quat_z     (quat.quat_z)
    );

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (quat.valid && !quat.ready) |-> !angles.ready)
        else $error("input accepted while output stalled");
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (quat.valid && !quat.ready) |=> quat.valid)
        else $error("output word dropped");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (v_chain[0] && en) |=> v_chain[1])
        else $error("word lost in cell chain");
endmodule
